// ===== hdl/mfmtf_pkg.sv =====
// ---------------------------------------------------------------------------
// MFM track formatter package
// Shared types, constants and the byte-wide CRC-16 update.
// ---------------------------------------------------------------------------
package mfmtf_pkg;

   localparam int MAX_SECTOR_BYTES = 1024;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 14;

   localparam logic [CSR_INDEX_W-1:0] CSR_TRACK_NUMBER      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIDE_NUMBER       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTORS_PER_TRACK = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTOR_BYTES      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRACK_LENGTH      = 3'd4;

   localparam logic [7:0]  RESET_SECTORS_PER_TRACK = 8'd9;
   localparam logic [10:0] RESET_SECTOR_BYTES      = 11'd512;
   localparam logic [13:0] RESET_TRACK_LENGTH      = 14'd6250;

   localparam logic [7:0] BYTE_GAP   = 8'h4E;
   localparam logic [7:0] BYTE_SYNC  = 8'h00;
   localparam logic [7:0] BYTE_MARK  = 8'hA1;
   localparam logic [7:0] BYTE_IAM   = 8'hFC;
   localparam logic [7:0] BYTE_IDAM  = 8'hFE;
   localparam logic [7:0] BYTE_DAM   = 8'hFB;
   localparam logic [7:0] BYTE_BLANK = 8'hE5;

   localparam logic [10:0] LEN_GAP4A = 11'd80;
   localparam logic [10:0] LEN_GAP1  = 11'd50;
   localparam logic [10:0] LEN_GAP2  = 11'd22;
   localparam logic [10:0] LEN_GAP3  = 11'd54;
   localparam logic [10:0] LEN_SYNC  = 11'd12;
   localparam logic [10:0] LEN_MARK  = 11'd4;
   localparam logic [10:0] LEN_CRC   = 11'd2;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       data_present;
      logic       sector_blank;
   } req_type;

   typedef struct packed {
      logic [7:0] track_byte;
      logic       took_data;
      logic       sync_mark;
      logic       is_last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  track_number;
      logic [7:0]  side_number;
      logic [7:0]  sectors_per_track;
      logic [10:0] sector_bytes;
      logic [13:0] track_length;
   } cfg_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] x;
      x = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
      end
      return x;
   endfunction

endpackage

// ===== hdl/mfmtf_csr.sv =====
// ---------------------------------------------------------------------------
// MFM track formatter configuration registers
// Holds the track, side, sector count, sector size and track length.
// ---------------------------------------------------------------------------
module mfmtf_csr
   import mfmtf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TRACK_NUMBER:      cfg_in.track_number      = csr_data[7:0];
            CSR_SIDE_NUMBER:       cfg_in.side_number       = csr_data[7:0];
            CSR_SECTORS_PER_TRACK: cfg_in.sectors_per_track = csr_data[7:0];
            CSR_SECTOR_BYTES:      cfg_in.sector_bytes      = csr_data[10:0];
            CSR_TRACK_LENGTH:      cfg_in.track_length      = csr_data[13:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.track_number      <= 8'd0;
         cfg_ff.side_number       <= 8'd0;
         cfg_ff.sectors_per_track <= RESET_SECTORS_PER_TRACK;
         cfg_ff.sector_bytes      <= RESET_SECTOR_BYTES;
         cfg_ff.track_length      <= RESET_TRACK_LENGTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/mfmtf_sequencer.sv =====
// ---------------------------------------------------------------------------
// MFM track formatter sequencer
// Walks the track layout one byte per request and keeps the running CRC.
// ---------------------------------------------------------------------------
module mfmtf_sequencer
   import mfmtf_pkg::*;
#(
   parameter int SECTOR_LIMIT = MAX_SECTOR_BYTES
)
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    advance,
   input  req_type req,
   output rsp_type rsp
);

   localparam logic [3:0] PH_GAP4A = 4'd0;
   localparam logic [3:0] PH_ISYNC = 4'd1;
   localparam logic [3:0] PH_IAM   = 4'd2;
   localparam logic [3:0] PH_GAP1  = 4'd3;
   localparam logic [3:0] PH_SSYNC = 4'd4;
   localparam logic [3:0] PH_IDAM  = 4'd5;
   localparam logic [3:0] PH_IDF   = 4'd6;
   localparam logic [3:0] PH_IDCRC = 4'd7;
   localparam logic [3:0] PH_GAP2  = 4'd8;
   localparam logic [3:0] PH_DSYNC = 4'd9;
   localparam logic [3:0] PH_DAM   = 4'd10;
   localparam logic [3:0] PH_DATA  = 4'd11;
   localparam logic [3:0] PH_DCRC  = 4'd12;
   localparam logic [3:0] PH_GAP3  = 4'd13;
   localparam logic [3:0] PH_FILL  = 4'd14;

   logic [3:0]  phase_ff, phase_in;
   logic [10:0] seg_ff, seg_in;
   logic [7:0]  sector_ff, sector_in;
   logic [13:0] count_ff, count_in;
   logic [15:0] crc_ff, crc_in;

   logic [10:0] data_len;
   logic [10:0] seg_len;
   logic [11:0] seg_inc;
   logic [7:0]  sector_inc;
   logic [7:0]  out_byte;
   logic [15:0] crc_base;
   logic        took, sync, last, end_struct;

   assign data_len = ({3'b000, cfg.sector_bytes} > 14'(SECTOR_LIMIT)) ?
                     11'(SECTOR_LIMIT) : cfg.sector_bytes;
   assign seg_inc    = {1'b0, seg_ff} + 12'd1;
   assign sector_inc = sector_ff + 8'd1;

   always_comb begin
      unique case (phase_ff)
         PH_GAP4A: seg_len = LEN_GAP4A;
         PH_GAP1:  seg_len = LEN_GAP1;
         PH_GAP2:  seg_len = LEN_GAP2;
         PH_GAP3:  seg_len = LEN_GAP3;
         PH_ISYNC, PH_SSYNC, PH_DSYNC: seg_len = LEN_SYNC;
         PH_IAM, PH_IDAM, PH_DAM, PH_IDF: seg_len = LEN_MARK;
         PH_IDCRC, PH_DCRC: seg_len = LEN_CRC;
         PH_DATA:  seg_len = data_len;
         default:  seg_len = 11'd1;
      endcase
   end

   always_comb begin
      out_byte = BYTE_GAP;
      took     = 1'b0;
      sync     = 1'b0;
      unique case (phase_ff)
         PH_ISYNC, PH_SSYNC, PH_DSYNC: out_byte = BYTE_SYNC;
         PH_IAM, PH_IDAM, PH_DAM: begin
            if (seg_ff < 11'd3) begin
               out_byte = BYTE_MARK;
               sync     = 1'b1;
            end else if (phase_ff == PH_IAM) begin
               out_byte = BYTE_IAM;
            end else if (phase_ff == PH_IDAM) begin
               out_byte = BYTE_IDAM;
            end else begin
               out_byte = BYTE_DAM;
            end
         end
         PH_IDF: begin
            if (seg_ff == 11'd0) begin
               out_byte = cfg.track_number;
            end else if (seg_ff == 11'd1) begin
               out_byte = cfg.side_number;
            end else if (seg_ff == 11'd2) begin
               out_byte = sector_inc;
            end else if (data_len >= 11'd1024) begin
               out_byte = 8'd3;
            end else if (data_len >= 11'd512) begin
               out_byte = 8'd2;
            end else if (data_len >= 11'd256) begin
               out_byte = 8'd1;
            end else begin
               out_byte = 8'd0;
            end
         end
         PH_IDCRC, PH_DCRC: out_byte = (seg_ff == 11'd0) ? crc_ff[15:8] : crc_ff[7:0];
         PH_DATA: begin
            took = 1'b1;
            if (req.sector_blank) begin
               out_byte = BYTE_BLANK;
            end else if (req.data_present) begin
               out_byte = req.data_byte;
            end else begin
               out_byte = BYTE_SYNC;
            end
         end
         default: out_byte = BYTE_GAP;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      seg_in     = seg_ff;
      sector_in  = sector_ff;
      crc_in     = crc_ff;
      last       = 1'b0;
      end_struct = 1'b0;
      crc_base   = (seg_ff == 11'd0) ? CRC_INIT : crc_ff;

      if (phase_ff == PH_IDAM || phase_ff == PH_DAM) begin
         crc_in = crc_byte(crc_base, out_byte);
      end else if (phase_ff == PH_IDF || phase_ff == PH_DATA) begin
         crc_in = crc_byte(crc_ff, out_byte);
      end

      count_in = (count_ff == 14'h3FFF) ? count_ff : count_ff + 14'd1;

      if (phase_ff == PH_FILL) begin
         last = (count_in >= cfg.track_length);
      end else if (seg_inc >= {1'b0, seg_len}) begin
         seg_in = 11'd0;
         unique case (phase_ff)
            PH_GAP1: begin
               if (cfg.sectors_per_track == 8'd0) begin
                  end_struct = 1'b1;
               end else begin
                  phase_in = PH_SSYNC;
               end
            end
            PH_DAM: phase_in = (data_len == 11'd0) ? PH_DCRC : PH_DATA;
            PH_GAP3: begin
               sector_in = sector_inc;
               if (sector_inc >= cfg.sectors_per_track || sector_inc == 8'd0) begin
                  end_struct = 1'b1;
               end else begin
                  phase_in = PH_SSYNC;
               end
            end
            default: phase_in = phase_ff + 4'd1;
         endcase
         if (end_struct) begin
            if (count_in >= cfg.track_length) begin
               last = 1'b1;
            end else begin
               phase_in = PH_FILL;
            end
         end
      end else begin
         seg_in = seg_inc[10:0];
      end

      if (last) begin
         phase_in  = PH_GAP4A;
         seg_in    = 11'd0;
         sector_in = 8'd0;
         count_in  = 14'd0;
         crc_in    = CRC_INIT;
      end
   end

   assign rsp.track_byte = out_byte;
   assign rsp.took_data  = took;
   assign rsp.sync_mark  = sync;
   assign rsp.is_last    = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_GAP4A;
         seg_ff    <= 11'd0;
         sector_ff <= 8'd0;
         count_ff  <= 14'd0;
         crc_ff    <= CRC_INIT;
      end else if (advance) begin
         phase_ff  <= phase_in;
         seg_ff    <= seg_in;
         sector_ff <= sector_in;
         count_ff  <= count_in;
         crc_ff    <= crc_in;
      end
   end

endmodule

// ===== hdl/mfm_track_formatter.sv =====
// ---------------------------------------------------------------------------
// MFM track formatter
// Emits one formatted double-density track byte for every request taken.
// ---------------------------------------------------------------------------
// Every request yields exactly one result, and a new request can be taken on
// every clock while the result is not stalled, so the sustained rate is one
// byte per cycle. A request passes an input register, the sequencer step
// (layout counters and a byte-wide CRC-16 update) and a result register.
// After the byte marked is_last the next request starts a new track.
// ---------------------------------------------------------------------------
module mfm_track_formatter
   import mfmtf_pkg::*;
#(
   parameter int SECTOR_LIMIT = MAX_SECTOR_BYTES
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg;
   req_type req_ff;
   logic    req_valid_ff, req_valid_in;
   rsp_type rsp_ff, rsp_next;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    out_free, advance, take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   assign req_valid_in = take ? 1'b1 : (advance ? 1'b0 : req_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   mfmtf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mfmtf_sequencer #(
      .SECTOR_LIMIT (SECTOR_LIMIT)
   ) u_sequencer (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .req     (req_ff),
      .rsp     (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== hdl/mfmtf_checker.sv =====
// ---------------------------------------------------------------------------
// MFM track formatter checker
// Port-level checks on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
module mfmtf_checker
   import mfmtf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("Stalled result changed or vanished.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result valid right after reset.");

   a_sync_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.sync_mark |-> rsp_payload.track_byte == BYTE_MARK)
      else $error("Missing-clock mark on a byte other than A1.");

   a_data_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.took_data |->
         !rsp_payload.sync_mark && !rsp_payload.is_last)
      else $error("Data slot flagged as mark or track end.");

endmodule

bind mfm_track_formatter mfmtf_checker u_checker (.*);
